/* rtl/core/ncp_pkg.sv */
package ncp_pkg;

  localparam logic [8:0] UNSET = 9'h1FF;
  localparam logic [7:0] LINK_LOW = 8'd2;
  localparam logic [7:0] LINK_HIGH = 8'd71;
  localparam logic [8:0] ECHO_LINK = 9'd72;
  localparam logic [7:0] ECHO_OK = 8'h10;
  localparam logic [7:0] CONN_FAIL = 8'hFF;

  typedef enum logic [3:0] {
    CMD_RTS = 4'd0, CMD_STR = 4'd1, CMD_CLS = 4'd2, CMD_CHK = 4'd3,
    CMD_ECO = 4'd4, CMD_ERP = 4'd5, CMD_ERR = 4'd6, CMD_RST = 4'd7,
    CMD_OPEN = 4'd8, CMD_LISTEN = 4'd9, CMD_ECHO = 4'd10, CMD_CLOSE = 4'd11,
    CMD_DEAD = 4'd12, CMD_NOP = 4'd13, CMD_R14 = 4'd14, CMD_R15 = 4'd15
  } cmd_t;

  localparam logic [3:0] K_RTS = 4'd0;
  localparam logic [3:0] K_STR = 4'd1;
  localparam logic [3:0] K_CLS = 4'd2;
  localparam logic [3:0] K_ERR = 4'd3;
  localparam logic [3:0] K_ERP = 4'd4;
  localparam logic [3:0] K_RRP = 4'd5;
  localparam logic [3:0] K_ECO = 4'd6;
  localparam logic [3:0] K_LREP = 4'd7;
  localparam logic [3:0] K_OREP = 4'd8;
  localparam logic [3:0] K_CREP = 4'd9;
  localparam logic [3:0] K_EREP = 4'd10;

  localparam logic [3:0] OP_RTS = 4'd1;
  localparam logic [3:0] OP_STR = 4'd2;
  localparam logic [3:0] OP_CLS = 4'd3;

  localparam logic [7:0] E_LINK = 8'd3;
  localparam logic [7:0] E_NOLINK = 8'd4;
  localparam logic [7:0] E_UNKNOWN = 8'd5;

  localparam logic [1:0] REG_RLINK = 2'd0;
  localparam logic [1:0] REG_BSIZE = 2'd1;
  localparam logic [1:0] REG_SBASE = 2'd2;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] in_host;
    logic [31:0] in_local_socket;
    logic [31:0] in_remote_socket;
    logic [7:0] in_byte;
    logic [3:0] in_opcode;
    logic [3:0] in_connection;
  } in_word_t;

  typedef struct packed {
    logic [3:0] out_kind;
    logic [7:0] out_host;
    logic [31:0] out_socket_first;
    logic [31:0] out_socket_second;
    logic [7:0] out_byte;
    logic [3:0] out_opcode;
    logic [7:0] out_connection;
    logic [7:0] out_echo_status;
    logic out_last;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic bad_link;
    in_word_t word;
  } task_t;

endpackage

/* rtl/core/ncp_front.sv */
module ncp_front (
  input logic clk,
  input logic rst,
  input logic start,
  input ncp_pkg::in_word_t item,
  input logic q_full,
  output logic busy,
  output logic push,
  output ncp_pkg::task_t push_task
);
  import ncp_pkg::*;

  logic hold;
  in_word_t held;

  assign busy = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (start && !hold) begin
      hold <= 1'b1;
      held <= item;
    end else if (hold && !q_full) begin
      hold <= 1'b0;
    end
  end

  always_comb begin
    push = hold && !q_full;
    push_task.valid = 1'b1;
    push_task.word = held;
    push_task.bad_link = 1'b0;
    if (held.command == CMD_RTS || held.command == CMD_STR) begin
      push_task.bad_link = held.in_byte < LINK_LOW || held.in_byte > LINK_HIGH;
    end
  end

endmodule

/* rtl/core/ncp_queue.sv */
module ncp_queue (
  input logic clk,
  input logic rst,
  input logic push,
  input ncp_pkg::task_t push_task,
  input logic pop,
  output logic full,
  output logic ready_out,
  output ncp_pkg::task_t head
);
  import ncp_pkg::*;

  task_t slot [2];
  logic [1:0] count;
  logic wp;
  logic rp;

  assign full = count == 2'd2;
  assign ready_out = count != 2'd0;
  assign head = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (push) begin
        slot[wp] <= push_task;
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/core/ncp_back.sv */
module ncp_back #(
  parameter int ENTRIES = 16
) (
  input logic clk,
  input logic rst,
  input logic q_ready,
  input ncp_pkg::task_t head,
  input logic [6:0] receive_link,
  input logic [7:0] byte_size,
  input logic [31:0] local_socket_base,
  output logic pop,
  output logic done,
  output ncp_pkg::out_word_t result
);
  import ncp_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT1, S_OUT2} state_t;

  state_t state;
  logic [IW:0] idx;
  in_word_t w;
  logic badl;

  logic [8:0] e_host [ENTRIES];
  logic [8:0] e_rl [ENTRIES];
  logic [8:0] e_sl [ENTRIES];
  logic [8:0] e_rz [ENTRIES];
  logic [8:0] e_sz [ENTRIES];
  logic [63:0] e_rs [ENTRIES];
  logic [63:0] e_ss [ENTRIES];
  logic [31:0] lsock [ENTRIES];

  logic f_link, f_local, f_pair, f_lis, f_free, f_lfree, f_echo;
  logic [IW-1:0] i_link, i_local, i_pair, i_free, i_lfree, i_echo;
  logic [IW-1:0] ci;
  logic [31:0] want_local;
  logic [63:0] want_pair;
  out_word_t r1, r2;
  logic n1, n2;

  assign ci = idx[IW-1:0];
  assign want_pair = {w.in_local_socket, w.in_remote_socket};
  assign want_local = (w.command == CMD_STR) ? w.in_local_socket - 32'd1
                                             : w.in_local_socket + 32'd1;
  assign pop = (state == S_IDLE) && q_ready;

  function automatic out_word_t mk(logic [3:0] k, logic [7:0] h, logic [31:0] s1,
                                    logic [31:0] s2, logic [7:0] b, logic [3:0] o,
                                    logic [7:0] c, logic [7:0] st);
    out_word_t x;
    x.out_kind = k; x.out_host = h; x.out_socket_first = s1;
    x.out_socket_second = s2; x.out_byte = b; x.out_opcode = o;
    x.out_connection = c; x.out_echo_status = st; x.out_last = 1'b0;
    return x;
  endfunction

  task automatic kill(input logic [IW-1:0] k);
    e_host[k] <= UNSET; e_rl[k] <= UNSET; e_sl[k] <= UNSET;
    e_rz[k] <= UNSET; e_sz[k] <= UNSET; e_rs[k] <= '0; e_ss[k] <= '0;
  endtask

  always_ff @(posedge clk) begin
    logic [IW-1:0] t;
    logic [8:0] rl, sl, rz, sz, hh;
    logic [63:0] rs, ss;
    logic gone;
    logic [31:0] s;
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < ENTRIES; k++) begin
        kill(IW'(k));
        lsock[k] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (q_ready) begin
            w <= head.word;
            badl <= head.bad_link;
            idx <= '0;
            {f_link, f_local, f_pair, f_lis, f_free, f_lfree, f_echo} <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (w.command == CMD_RST) begin
            if (e_host[ci] == {1'b0, w.in_host}) kill(ci);
          end
          if (!f_link && e_host[ci] == {1'b0, w.in_host} &&
              (e_rl[ci] == {1'b0, w.in_byte} || e_sl[ci] == {1'b0, w.in_byte})) begin
            f_link <= 1'b1; i_link <= ci;
          end
          if (!f_echo && e_host[ci] == {1'b0, w.in_host} &&
              (e_rl[ci] == ECHO_LINK || e_sl[ci] == ECHO_LINK)) begin
            f_echo <= 1'b1; i_echo <= ci;
          end
          if (!f_local && e_host[ci] == {1'b0, w.in_host} &&
              (e_rs[ci][63:32] == want_local || e_ss[ci][63:32] == want_local)) begin
            f_local <= 1'b1; i_local <= ci;
          end
          if (!f_pair && e_host[ci] == {1'b0, w.in_host} &&
              (e_rs[ci] == want_pair || e_ss[ci] == want_pair)) begin
            f_pair <= 1'b1; i_pair <= ci;
          end
          if (lsock[ci] != '0 && (lsock[ci] == w.in_local_socket ||
              lsock[ci] + 32'd1 == w.in_local_socket)) f_lis <= 1'b1;
          if (!f_free && e_host[ci] == UNSET) begin
            f_free <= 1'b1; i_free <= ci;
          end
          if (!f_lfree && lsock[ci] == '0) begin
            f_lfree <= 1'b1; i_lfree <= ci;
          end
          if (idx == (IW+1)'(ENTRIES - 1)) state <= S_EXEC;
          idx <= idx + 1'b1;
        end
        S_EXEC: begin
          n1 <= 1'b0; n2 <= 1'b0;
          r1 <= '0; r2 <= '0;
          state <= S_OUT1;
          case (w.command)
            CMD_RTS, CMD_STR: begin
              logic is_str;
              logic [3:0] op;
              logic ok;
              is_str = w.command == CMD_STR;
              op = is_str ? OP_STR : OP_RTS;
              ok = 1'b0;
              t = '0;
              if (badl) begin
                n1 <= 1'b1; r1 <= mk(K_ERR, w.in_host, '0, '0, E_LINK, op, '0, '0);
              end else if (!f_lis) begin
                if (!f_pair) begin
                  n1 <= 1'b1; r1 <= mk(K_ERR, w.in_host, '0, '0, E_UNKNOWN, op, '0, '0);
                end else begin
                  ok = 1'b1; t = i_pair;
                end
              end else if (f_local) begin
                ok = 1'b1; t = i_local;
              end else if (!f_free) begin
                n1 <= 1'b1; r1 <= mk(K_ERR, w.in_host, '0, '0, E_UNKNOWN, op, '0, '0);
              end else begin
                ok = 1'b1; t = i_free;
              end
              if (ok) begin
                hh = e_host[t]; rl = e_rl[t]; sl = e_sl[t]; rz = e_rz[t]; sz = e_sz[t];
                rs = e_rs[t]; ss = e_ss[t];
                if (f_lis && !f_local) begin
                  hh = {1'b0, w.in_host};
                  rs = is_str ? want_pair : '0;
                  ss = is_str ? '0 : want_pair;
                end else if (f_lis) begin
                  if (is_str) rs = want_pair; else ss = want_pair;
                end
                if (is_str) begin
                  sz = {1'b0, w.in_byte};
                  if (rl == UNSET) begin
                    rl = {2'b0, receive_link};
                    n1 <= 1'b1;
                    r1 <= mk(K_RTS, hh[7:0], w.in_local_socket, w.in_remote_socket,
                             {1'b0, receive_link}, '0, '0, '0);
                    if (rz != UNSET) begin
                      n2 <= 1'b1;
                      r2 <= mk(K_LREP, w.in_host, ss[63:32], '0, '0, '0, 8'(t), '0);
                    end
                  end else if (sl != UNSET) begin
                    n1 <= 1'b1;
                    r1 <= mk(K_OREP, w.in_host, rs[31:0], '0, '0, '0, 8'(t), '0);
                  end
                end else begin
                  sl = {1'b0, w.in_byte};
                  if (rz == UNSET) begin
                    rz = {1'b0, byte_size};
                    n1 <= 1'b1;
                    r1 <= mk(K_STR, hh[7:0], w.in_local_socket, w.in_remote_socket,
                             byte_size, '0, '0, '0);
                    if (rl != UNSET) begin
                      n2 <= 1'b1;
                      r2 <= mk(K_LREP, w.in_host, ss[63:32], '0, '0, '0, 8'(t), '0);
                    end
                  end else if (sz != UNSET) begin
                    n1 <= 1'b1;
                    r1 <= mk(K_OREP, w.in_host, rs[31:0], '0, '0, '0, 8'(t), '0);
                  end
                end
                e_host[t] <= hh; e_rl[t] <= rl; e_sl[t] <= sl; e_rz[t] <= rz;
                e_sz[t] <= sz; e_rs[t] <= rs; e_ss[t] <= ss;
              end
            end
            CMD_CLS: begin
              if (!f_pair) begin
                n1 <= 1'b1;
                r1 <= mk(K_ERR, w.in_host, '0, '0, E_NOLINK, OP_CLS, '0, '0);
              end else begin
                t = i_pair;
                rs = e_rs[t]; ss = e_ss[t];
                if (rs[63:32] == w.in_local_socket) rs = '0;
                if (ss[63:32] == w.in_local_socket) ss = '0;
                gone = rs[63:32] == '0 && ss[63:32] == '0;
                e_rs[t] <= rs; e_ss[t] <= ss;
                if (e_sz[t] == UNSET) begin
                  if (gone) begin
                    lsock[t] <= '0; kill(t);
                    n1 <= 1'b1; r1 <= mk(K_CREP, '0, '0, '0, '0, '0, 8'(t), '0);
                  end
                end else begin
                  n1 <= 1'b1;
                  r1 <= mk(K_CLS, e_host[t][7:0], w.in_local_socket,
                           w.in_remote_socket, '0, '0, '0, '0);
                  if (gone) begin
                    kill(t);
                    n2 <= 1'b1; r2 <= mk(K_CREP, '0, '0, '0, '0, '0, 8'(t), '0);
                  end
                end
              end
            end
            CMD_CHK: begin
              if (!f_link) begin
                n1 <= 1'b1;
                r1 <= mk(K_ERR, w.in_host, '0, '0, E_NOLINK, w.in_opcode, '0, '0);
              end
            end
            CMD_ECO: begin
              n1 <= 1'b1; r1 <= mk(K_ERP, w.in_host, '0, '0, w.in_byte, '0, '0, '0);
            end
            CMD_ERP, CMD_DEAD: begin
              if (f_echo) begin
                n1 <= 1'b1;
                r1 <= mk(K_EREP, w.in_host, '0, '0,
                         (w.command == CMD_ERP) ? w.in_byte : 8'd0, '0, '0,
                         (w.command == CMD_ERP) ? ECHO_OK : {4'd0, w.in_byte[3:0]});
                kill(i_echo);
              end
            end
            CMD_ERR: begin
              if ((w.in_byte == E_NOLINK || w.in_byte == E_UNKNOWN) &&
                  (w.in_opcode == OP_RTS || w.in_opcode == OP_STR) && f_pair) begin
                s = w.in_remote_socket;
                if (!s[0]) s = s - 32'd1;
                n1 <= 1'b1; r1 <= mk(K_OREP, w.in_host, s, '0, '0, '0, CONN_FAIL, '0);
                kill(i_pair);
              end
            end
            CMD_RST: begin
              n1 <= 1'b1; r1 <= mk(K_RRP, w.in_host, '0, '0, '0, '0, '0, '0);
            end
            CMD_OPEN: begin
              if (!f_free) begin
                n1 <= 1'b1;
                r1 <= mk(K_OREP, w.in_host, w.in_local_socket, '0, '0, '0, CONN_FAIL, '0);
              end else begin
                t = i_free;
                e_host[t] <= {1'b0, w.in_host};
                e_rs[t] <= {local_socket_base, w.in_local_socket};
                e_ss[t] <= {local_socket_base + 32'd1, w.in_local_socket + 32'd1};
                e_rl[t] <= {2'b0, receive_link};
                e_rz[t] <= {1'b0, byte_size};
                n1 <= 1'b1; n2 <= 1'b1;
                r1 <= mk(K_RTS, w.in_host, local_socket_base, w.in_local_socket,
                         {1'b0, receive_link}, '0, '0, '0);
                r2 <= mk(K_STR, w.in_host, local_socket_base + 32'd1,
                         w.in_local_socket + 32'd1, byte_size, '0, '0, '0);
              end
            end
            CMD_LISTEN: begin
              if (f_lis || !f_lfree) begin
                n1 <= 1'b1; r1 <= mk(K_LREP, '0, w.in_local_socket, '0, '0, '0, '0, '0);
              end else begin
                lsock[i_lfree] <= w.in_local_socket;
              end
            end
            CMD_ECHO: begin
              if (f_free) begin
                e_host[i_free] <= {1'b0, w.in_host};
                e_rl[i_free] <= ECHO_LINK;
                n1 <= 1'b1; r1 <= mk(K_ECO, w.in_host, '0, '0, w.in_byte, '0, '0, '0);
              end
            end
            CMD_CLOSE: begin
              if ({28'd0, w.in_connection} < 32'(ENTRIES) &&
                  e_host[IW'(w.in_connection)] != UNSET) begin
                t = IW'(w.in_connection);
                e_sz[t] <= UNSET; e_rz[t] <= UNSET;
                n1 <= 1'b1; n2 <= 1'b1;
                r1 <= mk(K_CLS, e_host[t][7:0], e_rs[t][63:32], e_rs[t][31:0],
                         '0, '0, '0, '0);
                r2 <= mk(K_CLS, e_host[t][7:0], e_ss[t][63:32], e_ss[t][31:0],
                         '0, '0, '0, '0);
              end
            end
            default: begin
            end
          endcase
        end
        S_OUT1: begin
          if (n1) begin
            done <= 1'b1;
            result <= r1;
            result.out_last <= !n2;
          end
          state <= n2 ? S_OUT2 : S_IDLE;
        end
        S_OUT2: begin
          done <= 1'b1;
          result <= r2;
          result.out_last <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ncp_connection_table_engine.sv */
// Channel   Handshake            Word
// command   start / busy         command
// result    done (one cycle)     result
// config    cfg_we               cfg_index, cfg_data
// A result passes from the front hold register through the two-deep queue to the
// back end, which scans the table, executes and then outputs it; a second result
// follows in the next cycle. The back end scans one table entry per cycle.
// Reset clears the tables at once; the engine is ready the cycle after.
// The receiver cannot stall; results show for one cycle each.
// busy is high for the cycle after each accepted word, and longer while the
// two-deep queue to the back end is full.
module ncp_connection_table_engine #(
  parameter int TABLE_ENTRIES = 16
) (
  input logic clk,
  input logic rst,
  input logic start,
  input ncp_pkg::in_word_t command,
  output logic busy,
  output logic done,
  output ncp_pkg::out_word_t result,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [31:0] cfg_data
);
  import ncp_pkg::*;

  logic [6:0] receive_link;
  logic [7:0] byte_size;
  logic [31:0] local_socket_base;
  logic push, pop, q_full, q_ready;
  task_t push_task, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_link <= 7'd42;
      byte_size <= 8'd8;
      local_socket_base <= 32'd1002;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RLINK: receive_link <= cfg_data[6:0];
        REG_BSIZE: byte_size <= cfg_data[7:0];
        REG_SBASE: local_socket_base <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ncp_front u_front (
    .clk, .rst, .start, .item(command), .q_full, .busy, .push, .push_task
  );

  ncp_queue u_queue (
    .clk, .rst, .push, .push_task, .pop, .full(q_full), .ready_out(q_ready), .head
  );

  ncp_back #(.ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst, .q_ready, .head, .receive_link, .byte_size, .local_socket_base,
    .pop, .done, .result
  );

endmodule

/* rtl/core/ncp_checker.sv */
module ncp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input ncp_pkg::out_word_t result
);
  import ncp_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("activity after reset");
  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted word did not raise busy");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> result.out_kind <= K_EREP) else $error("bad kind");
  a_fail_conn: assert property (@(posedge clk) disable iff (rst)
    done && result.out_connection == CONN_FAIL |-> result.out_kind == K_OREP)
    else $error("failed open on wrong kind");
  a_pair: assert property (@(posedge clk) disable iff (rst)
    done && !result.out_last |=> done && result.out_last)
    else $error("unfinished pair");
endmodule

bind ncp_connection_table_engine ncp_checker u_checker (
  .clk, .rst, .start, .busy, .done, .result
);
